### rtl/fft64_pkg.sv
// ----------------------------------------------------------------------------
// fft64_pkg
// Shared types, constants and the twiddle table of the 64-point FFT core.
// ----------------------------------------------------------------------------
package fft64_pkg;

  localparam int N_POINTS     = 64;
  localparam int LOG2_POINTS  = 6;
  localparam int SAMPLE_W     = 8;
  localparam int DATA_W       = 2 * SAMPLE_W;        // {real, imag}
  localparam int BANK_DEPTH   = N_POINTS / 2;        // two banks
  localparam int BANK_AW      = LOG2_POINTS - 1;
  localparam int TW_AW        = LOG2_POINTS - 1;
  localparam int Q_SHIFT      = 6;                   // Q6 twiddles
  localparam int PROD_W       = 2 * SAMPLE_W;
  localparam int DRAIN_CYCLES = 2;                   // read-to-write latency
  localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

  // Sequencer states
  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_FFT,
    ST_DRAIN,
    ST_OUTPUT
  } fft_state_t;

  // Butterfly request issued together with the bank reads
  typedef struct packed {
    logic               valid;
    logic               swap;     // top entry lives in bank 1
    logic [TW_AW-1:0]   tw_idx;
    logic [BANK_AW-1:0] addr0;    // bank 0 address
    logic [BANK_AW-1:0] addr1;    // bank 1 address
  } bfly_req_t;

  // Write-back of one butterfly, one entry per bank
  typedef struct packed {
    logic               we;
    logic [BANK_AW-1:0] addr0;
    logic [BANK_AW-1:0] addr1;
    logic [DATA_W-1:0]  data0;
    logic [DATA_W-1:0]  data1;
  } bank_wr_t;

  // Twiddle table: cos in the high byte, sin in the low byte, Q6
  function automatic logic [DATA_W-1:0] twiddle(input logic [TW_AW-1:0] idx);
    logic [DATA_W-1:0] w;
    case (idx)
      5'd0:  w = 16'h4000;
      5'd1:  w = 16'h4006;
      5'd2:  w = 16'h3F0C;
      5'd3:  w = 16'h3D13;
      5'd4:  w = 16'h3B18;
      5'd5:  w = 16'h381E;
      5'd6:  w = 16'h3524;
      5'd7:  w = 16'h3129;
      5'd8:  w = 16'h2D2D;
      5'd9:  w = 16'h2931;
      5'd10: w = 16'h2435;
      5'd11: w = 16'h1E38;
      5'd12: w = 16'h183B;
      5'd13: w = 16'h133D;
      5'd14: w = 16'h0C3F;
      5'd15: w = 16'h0640;
      5'd16: w = 16'h0040;
      5'd17: w = 16'hFA40;
      5'd18: w = 16'hF43F;
      5'd19: w = 16'hED3D;
      5'd20: w = 16'hE83B;
      5'd21: w = 16'hE238;
      5'd22: w = 16'hDC35;
      5'd23: w = 16'hD731;
      5'd24: w = 16'hD32D;
      5'd25: w = 16'hCF29;
      5'd26: w = 16'hCB24;
      5'd27: w = 16'hC81E;
      5'd28: w = 16'hC518;
      5'd29: w = 16'hC313;
      5'd30: w = 16'hC10C;
      5'd31: w = 16'hC006;
      default: w = 16'h4000;
    endcase
    return w;
  endfunction

  // Bit reversal of a point index
  function automatic logic [LOG2_POINTS-1:0] bit_rev(input logic [LOG2_POINTS-1:0] v);
    logic [LOG2_POINTS-1:0] r;
    for (int i = 0; i < LOG2_POINTS; i++) begin
      r[i] = v[LOG2_POINTS-1-i];
    end
    return r;
  endfunction

endpackage

### rtl/fft64_in_if.sv
// ----------------------------------------------------------------------------
// fft64_in_if
// Sample channel: valid/ready handshake with one signed real sample.
// ----------------------------------------------------------------------------
interface fft64_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [fft64_pkg::SAMPLE_W-1:0]  sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

### rtl/fft64_out_if.sv
// ----------------------------------------------------------------------------
// fft64_out_if
// Bin channel: valid/ready handshake with one complex bin per request.
// ----------------------------------------------------------------------------
interface fft64_out_if;
  logic                                     valid;
  logic                                     ready;
  logic        [fft64_pkg::LOG2_POINTS-1:0] bin_index;
  logic signed [fft64_pkg::SAMPLE_W-1:0]    bin_real;
  logic signed [fft64_pkg::SAMPLE_W-1:0]    bin_imag;
  logic                                     last_bin;

  modport source (output valid, output bin_index, output bin_real, output bin_imag,
                  output last_bin, input ready);
  modport sink   (input valid, input bin_index, input bin_real, input bin_imag,
                  input last_bin, output ready);
endinterface

### rtl/fft64_ram.sv
// ----------------------------------------------------------------------------
// fft64_ram
// Generic single-write, single-read RAM with registered, enabled read.
// ----------------------------------------------------------------------------
module fft64_ram #(
  parameter int  WIDTH = 16,
  parameter int  DEPTH = 32,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, holds its data while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/fft64_bfly.sv
// ----------------------------------------------------------------------------
// fft64_bfly
// Two-stage radix-2 butterfly: twiddle multiply, then add/subtract, halve
// and write back to the two banks.
// ----------------------------------------------------------------------------
module fft64_bfly (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fft64_pkg::bfly_req_t           req,
  input  logic [fft64_pkg::DATA_W-1:0]   d0,
  input  logic [fft64_pkg::DATA_W-1:0]   d1,
  output fft64_pkg::bank_wr_t            wr
);

  localparam int SW = fft64_pkg::SAMPLE_W;
  localparam int PW = fft64_pkg::PROD_W;
  localparam int QS = fft64_pkg::Q_SHIFT;

  // operand select and twiddle lookup
  logic [fft64_pkg::DATA_W-1:0] a_w, b_w, tw;
  logic signed [SW-1:0]         c, s, br, bi;
  logic signed [PW-1:0]         p_cr, p_si, p_ci, p_sr;

  always_comb begin
    a_w  = req.swap ? d1 : d0;
    b_w  = req.swap ? d0 : d1;
    tw   = fft64_pkg::twiddle(req.tw_idx);
    c    = tw[2*SW-1:SW];
    s    = tw[SW-1:0];
    br   = b_w[2*SW-1:SW];
    bi   = b_w[SW-1:0];
    p_cr = c * br;
    p_si = s * bi;
    p_ci = c * bi;
    p_sr = s * br;
  end

  // product stage registers
  logic                         v2_r;
  fft64_pkg::bfly_req_t         req2_r;
  logic signed [PW-1:0]         p_cr_r, p_si_r, p_ci_r, p_sr_r;
  logic [fft64_pkg::DATA_W-1:0] a_r, b_r;
  logic                         cz_r, sz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    req2_r <= req;
    p_cr_r <= p_cr;
    p_si_r <= p_si;
    p_ci_r <= p_ci;
    p_sr_r <= p_sr;
    a_r    <= a_w;
    b_r    <= b_w;
    cz_r   <= (c == '0);
    sz_r   <= (s == '0);
  end

  // rotated term and butterfly
  logic signed [PW:0]   rot_re, rot_im;
  logic signed [SW:0]   tr, ti;
  logic signed [SW-1:0] ar, ai, br2, bi2;
  logic signed [SW+1:0] sum_re, sum_im, dif_re, dif_im;
  logic [fft64_pkg::DATA_W-1:0] top_val, bot_val;

  always_comb begin
    ar     = a_r[2*SW-1:SW];
    ai     = a_r[SW-1:0];
    br2    = b_r[2*SW-1:SW];
    bi2    = b_r[SW-1:0];
    rot_re = (PW+1)'(p_cr_r) - (PW+1)'(p_si_r);
    rot_im = (PW+1)'(p_ci_r) + (PW+1)'(p_sr_r);
    if (cz_r) begin
      // quarter turn: (-imag, real), exact
      tr = -(SW+1)'(bi2);
      ti = (SW+1)'(br2);
    end else if (sz_r) begin
      tr = (SW+1)'(br2);
      ti = (SW+1)'(bi2);
    end else begin
      // shift right by Q_SHIFT, wrap to eight bits
      tr = (SW+1)'($signed(rot_re[QS+SW-1:QS]));
      ti = (SW+1)'($signed(rot_im[QS+SW-1:QS]));
    end
    sum_re  = (SW+2)'(ar) + (SW+2)'(tr);
    sum_im  = (SW+2)'(ai) + (SW+2)'(ti);
    dif_re  = (SW+2)'(ar) - (SW+2)'(tr);
    dif_im  = (SW+2)'(ai) - (SW+2)'(ti);
    top_val = {sum_re[SW:1], sum_im[SW:1]};
    bot_val = {dif_re[SW:1], dif_im[SW:1]};
  end

  // route results to the banks
  always_comb begin
    wr.we    = v2_r;
    wr.addr0 = req2_r.addr0;
    wr.addr1 = req2_r.addr1;
    wr.data0 = req2_r.swap ? bot_val : top_val;
    wr.data1 = req2_r.swap ? top_val : bot_val;
  end

endmodule

### rtl/fixed_point_fft_64_core.sv
// ----------------------------------------------------------------------------
// fixed_point_fft_64_core
// 64-point radix-2 DIT FFT of real 8-bit samples with per-stage halving.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while a frame is being collected; each is
// written to its bit-reversed slot of a work buffer split into two 32-entry
// banks (bank = parity of the index), so both entries of a butterfly are
// read and written in the same cycle. After the 64th sample the block stops
// taking samples, runs six stages of 32 butterflies at one butterfly per
// cycle plus a drain per stage that covers the read-to-write latency of
// the butterfly pipeline, then streams the 64 bins in index order at one
// per cycle when the sink is ready. The output phase covers the 64 reads,
// the read latency of the banks and the hand back to collection. If the
// sink holds off, the last bin waits in the output register while the next
// frame is collected.
// ----------------------------------------------------------------------------
module fixed_point_fft_64_core (
  input  logic         clk,
  input  logic         rst_n,
  fft64_in_if.sink     in_ch,
  fft64_out_if.source  out_ch
);

  localparam int LP = fft64_pkg::LOG2_POINTS;
  localparam int AW = fft64_pkg::BANK_AW;
  localparam int DW = fft64_pkg::DATA_W;
  localparam int SW = fft64_pkg::SAMPLE_W;
  localparam int LW = $clog2(LP + 1);

  // sequencer registers
  fft64_pkg::fft_state_t state_r, state_nxt;
  logic [LP-1:0]                  cnt_r, cnt_nxt;
  logic [LW-1:0]                  lvl_r, lvl_nxt;
  logic [AW-1:0]                  bf_r, bf_nxt;
  logic [fft64_pkg::DRAIN_W-1:0]  drain_r, drain_nxt;
  logic [LP:0]                    outk_r, outk_nxt;
  fft64_pkg::bfly_req_t           req_r, req_nxt;

  // output path registers
  logic          p_valid_r, p_valid_nxt;
  logic          p_bank_r;
  logic [LP-1:0] p_idx_r;
  logic          out_valid_r, out_valid_nxt;
  logic [LP-1:0] out_index_r;
  logic [SW-1:0] out_real_r, out_imag_r;
  logic          out_last_r;

  // bank ports
  logic [DW-1:0]   rdata0, rdata1;
  logic            we0, we1, re;
  logic [AW-1:0]   waddr0, waddr1, raddr0, raddr1;
  logic [DW-1:0]   wdata0, wdata1;
  fft64_pkg::bank_wr_t bwr;

  // handshake terms
  logic          in_acc, stall_out, issue_out, fft_issue;
  logic          stage_end, drain_end, frame_end, out_done;
  logic [LP-1:0] in_slot;

  // butterfly address generation
  logic [LP-1:0] half, lowmask, bf6, top_a, bot_a;
  logic          swap;
  logic [AW-1:0] tw_idx;

  always_comb begin
    half    = LP'(1) << lvl_r;
    lowmask = half - LP'(1);
    bf6     = LP'(bf_r);
    top_a   = ((bf6 & ~lowmask) << 1) | (bf6 & lowmask);
    bot_a   = top_a | half;
    swap    = ^top_a;
    tw_idx  = AW'(bf6 & lowmask) << (LW'(AW) - lvl_r);
  end

  // status terms
  always_comb begin
    in_acc    = in_ch.valid && in_ch.ready;
    in_slot   = fft64_pkg::bit_rev(cnt_r);
    frame_end = in_acc && (cnt_r == LP'(fft64_pkg::N_POINTS - 1));
    stage_end = (bf_r == AW'(fft64_pkg::BANK_DEPTH - 1));
    drain_end = (drain_r == fft64_pkg::DRAIN_W'(fft64_pkg::DRAIN_CYCLES - 1));
    stall_out = out_valid_r && !out_ch.ready;
    out_done  = outk_r[LP] && !p_valid_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fft64_pkg::ST_COLLECT: if (frame_end) state_nxt = fft64_pkg::ST_FFT;
      fft64_pkg::ST_FFT:     if (stage_end) state_nxt = fft64_pkg::ST_DRAIN;
      fft64_pkg::ST_DRAIN: begin
        if (drain_end) begin
          state_nxt = (lvl_r == LW'(LP)) ? fft64_pkg::ST_OUTPUT : fft64_pkg::ST_FFT;
        end
      end
      fft64_pkg::ST_OUTPUT:  if (out_done) state_nxt = fft64_pkg::ST_COLLECT;
      default:               state_nxt = fft64_pkg::ST_COLLECT;
    endcase
  end

  // state outputs
  always_comb begin
    in_ch.ready = 1'b0;
    fft_issue   = 1'b0;
    issue_out   = 1'b0;
    unique case (state_r)
      fft64_pkg::ST_COLLECT: in_ch.ready = 1'b1;
      fft64_pkg::ST_FFT:     fft_issue   = 1'b1;
      fft64_pkg::ST_DRAIN:   ;
      fft64_pkg::ST_OUTPUT:  issue_out   = !outk_r[LP] && !(p_valid_r && stall_out);
      default:               ;
    endcase
  end

  // counters and butterfly request
  always_comb begin
    cnt_nxt   = cnt_r;
    lvl_nxt   = lvl_r;
    bf_nxt    = bf_r;
    drain_nxt = drain_r;
    outk_nxt  = outk_r;
    if (in_acc) begin
      cnt_nxt = cnt_r + LP'(1);
    end
    if (frame_end) begin
      lvl_nxt = '0;
      bf_nxt  = '0;
    end
    if (fft_issue) begin
      bf_nxt    = bf_r + AW'(1);
      drain_nxt = '0;
      if (stage_end) begin
        lvl_nxt = lvl_r + LW'(1);
      end
    end
    if (state_r == fft64_pkg::ST_DRAIN) begin
      drain_nxt = drain_r + fft64_pkg::DRAIN_W'(1);
      if (drain_end) begin
        outk_nxt = '0;
      end
    end
    if (issue_out) begin
      outk_nxt = outk_r + (LP+1)'(1);
    end

    req_nxt.valid = fft_issue;
    req_nxt.swap  = swap;
    req_nxt.tw_idx = tw_idx;
    req_nxt.addr0 = swap ? bot_a[AW-1:0] : top_a[AW-1:0];
    req_nxt.addr1 = swap ? top_a[AW-1:0] : bot_a[AW-1:0];
  end

  // output pipeline: bank read stage, then output register
  always_comb begin
    p_valid_nxt = p_valid_r;
    if (issue_out) begin
      p_valid_nxt = 1'b1;
    end else if (!stall_out) begin
      p_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (p_valid_r && !stall_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fft64_pkg::ST_COLLECT;
      cnt_r       <= '0;
      lvl_r       <= '0;
      bf_r        <= '0;
      drain_r     <= '0;
      outk_r      <= '0;
      req_r       <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      lvl_r       <= lvl_nxt;
      bf_r        <= bf_nxt;
      drain_r     <= drain_nxt;
      outk_r      <= outk_nxt;
      req_r       <= req_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers of the output path
  always_ff @(posedge clk) begin
    if (issue_out) begin
      p_bank_r <= ^outk_r[LP-1:0];
      p_idx_r  <= outk_r[LP-1:0];
    end
    if (p_valid_r && !stall_out) begin
      out_index_r <= p_idx_r;
      out_real_r  <= p_bank_r ? rdata1[DW-1:SW] : rdata0[DW-1:SW];
      out_imag_r  <= p_bank_r ? rdata1[SW-1:0]  : rdata0[SW-1:0];
      out_last_r  <= (p_idx_r == LP'(fft64_pkg::N_POINTS - 1));
    end
  end

  // bank port muxing: butterfly write-back or incoming sample
  always_comb begin
    re     = fft_issue || issue_out;
    raddr0 = fft_issue ? req_nxt.addr0 : outk_r[AW-1:0];
    raddr1 = fft_issue ? req_nxt.addr1 : outk_r[AW-1:0];
    if (bwr.we) begin
      we0    = 1'b1;
      we1    = 1'b1;
      waddr0 = bwr.addr0;
      waddr1 = bwr.addr1;
      wdata0 = bwr.data0;
      wdata1 = bwr.data1;
    end else begin
      we0    = in_acc && !(^in_slot);
      we1    = in_acc && (^in_slot);
      waddr0 = in_slot[AW-1:0];
      waddr1 = in_slot[AW-1:0];
      wdata0 = {in_ch.sample, SW'(0)};
      wdata1 = {in_ch.sample, SW'(0)};
    end
  end

  fft64_ram #(
    .WIDTH (DW),
    .DEPTH (fft64_pkg::BANK_DEPTH)
  ) u_bank0 (
    .clk   (clk),
    .we    (we0),
    .waddr (waddr0),
    .wdata (wdata0),
    .re    (re),
    .raddr (raddr0),
    .rdata (rdata0)
  );

  fft64_ram #(
    .WIDTH (DW),
    .DEPTH (fft64_pkg::BANK_DEPTH)
  ) u_bank1 (
    .clk   (clk),
    .we    (we1),
    .waddr (waddr1),
    .wdata (wdata1),
    .re    (re),
    .raddr (raddr1),
    .rdata (rdata1)
  );

  fft64_bfly u_bfly (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_r),
    .d0    (rdata0),
    .d1    (rdata1),
    .wr    (bwr)
  );

  // result channel
  assign out_ch.valid     = out_valid_r;
  assign out_ch.bin_index = out_index_r;
  assign out_ch.bin_real  = out_real_r;
  assign out_ch.bin_imag  = out_imag_r;
  assign out_ch.last_bin  = out_last_r;

endmodule
